/* design/spm_pkg.sv */
// spm_pkg: shared constants and types for the slotted page manager
// no dependencies; imported by the top level
`default_nettype none

package spm_pkg;

  // default geometry of the page
  localparam int PAGE_BYTES_DEF   = 4096;
  localparam int HEADER_BYTES_DEF = 24;
  localparam int MAX_SLOTS_DEF    = 1024;
  localparam int SLOT_BYTES       = 4;

  // fixed port widths
  localparam int MODE_W   = 3;
  localparam int LEN_W    = 13;
  localparam int BYTE_W   = 8;
  localparam int SLOT_W   = 10;
  localparam int INDEX_W  = 12;
  localparam int STATUS_W = 3;
  localparam int PAGEID_W = 32;

  // operation codes
  localparam logic [MODE_W-1:0] MODE_INSERT  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_READ    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_DELETE  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_COMPACT = 3'd3;
  localparam logic [MODE_W-1:0] MODE_FORMAT  = 3'd4;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NOSPACE = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BEYOND  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DELETED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_INDEX   = 3'd4;

  typedef enum logic [2:0] {
    INS_IDLE   = 3'b001,
    INS_WRITE  = 3'b010,
    INS_REJECT = 3'b100
  } ins_state_t;

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_INS     = 9'b000000010,
    S_RD_SLOT = 9'b000000100,
    S_RD_BYTE = 9'b000001000,
    S_DEL     = 9'b000010000,
    S_CP_SLOT = 9'b000100000,
    S_CP_CHK  = 9'b001000000,
    S_CP_RD   = 9'b010000000,
    S_CP_WR   = 9'b100000000
  } seq_state_t;

endpackage

`default_nettype wire

/* design/spm_ram.sv */
// spm_ram: generic simple dual port ram, one write and one registered read
// no dependencies
`default_nettype none

module spm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* design/slotted_page_manager.sv */
// slotted_page_manager: one slotted database page with insert, read, delete,
// compact and format; uses spm_pkg and two spm_ram instances
//
//   channel | handshake              | payload
//   --------+------------------------+----------------------------------------
//   in      | in_valid / in_stall    | mode tuple_length data_byte last_byte
//           |                        | slot_select byte_index
//   out     | out_valid / out_stall  | status slot_number page_id_out length_out
//           |                        | byte_out free_pointer_out
//   cfg     | cfg_write_en           | cfg_write_data (page_number)
//
// insert byte and delete each pass through one state (S_INS, S_DEL); read goes
// through S_RD_SLOT and, for a byte in range, S_RD_BYTE; format and a read or
// delete beyond the slot count answer from idle; the slot and tuple rams each have
// one registered read port, which sets these steps. compact visits S_CP_SLOT and
// S_CP_CHK per slot, then S_CP_RD and S_CP_WR per byte moved through the tuple ram.
// the block takes one transaction at a time; a waiting result holds off the next one.
// rst is synchronous: empty page, free pointer at page end, no insert pending.
`default_nettype none

module slotted_page_manager #(
  parameter int PAGE_BYTES   = spm_pkg::PAGE_BYTES_DEF,
  parameter int HEADER_BYTES = spm_pkg::HEADER_BYTES_DEF,
  parameter int MAX_SLOTS    = spm_pkg::MAX_SLOTS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_write_en,
  input  wire logic [spm_pkg::PAGEID_W-1:0]  cfg_write_data,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [spm_pkg::MODE_W-1:0]    mode,
  input  wire logic [spm_pkg::LEN_W-1:0]     tuple_length,
  input  wire logic [spm_pkg::BYTE_W-1:0]    data_byte,
  input  wire logic                          last_byte,
  input  wire logic [spm_pkg::SLOT_W-1:0]    slot_select,
  input  wire logic [spm_pkg::INDEX_W-1:0]   byte_index,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [spm_pkg::STATUS_W-1:0]       status,
  output logic [spm_pkg::SLOT_W-1:0]         slot_number,
  output logic [spm_pkg::PAGEID_W-1:0]       page_id_out,
  output logic [spm_pkg::LEN_W-1:0]          length_out,
  output logic [spm_pkg::BYTE_W-1:0]         byte_out,
  output logic [spm_pkg::LEN_W-1:0]          free_pointer_out
);

  import spm_pkg::*;

  localparam int AW  = $clog2(PAGE_BYTES);
  localparam int PW  = $clog2(PAGE_BYTES + 1);
  localparam int SW  = $clog2(MAX_SLOTS);
  localparam int CW  = $clog2(MAX_SLOTS + 1);
  localparam int XW  = (CW > SLOT_W) ? CW : SLOT_W;
  localparam int CW4 = CW + 3;
  localparam int M1  = (PW > CW4) ? PW : CW4;
  localparam int CALCW = ((M1 > LEN_W + 1) ? M1 : LEN_W + 1) + 1;

  localparam logic [CALCW-1:0] PAGE_C   = CALCW'(PAGE_BYTES);
  localparam logic [CALCW-1:0] HEADER_C = CALCW'(HEADER_BYTES);
  localparam logic [CALCW-1:0] SLOTB_C  = CALCW'(SLOT_BYTES);
  localparam logic [CW-1:0]    MAXS_C   = CW'(MAX_SLOTS);
  localparam logic [PW-1:0]    PAGE_P   = PW'(PAGE_BYTES);

  seq_state_t state, state_next;
  ins_state_t ins_state, ins_state_next;
  logic [PW-1:0] ins_pos, ins_pos_next;
  logic [PW-1:0] ins_len, ins_len_next;
  logic [PW-1:0] fp, fp_next;
  logic [CW-1:0] total, total_next;
  logic [PAGEID_W-1:0] page_reg;

  logic [CW-1:0] cp_i, cp_i_next;
  logic [PW-1:0] cp_next, cp_next_next;
  logic [PW-1:0] cp_src, cp_src_next;
  logic [PW-1:0] cp_dst, cp_dst_next;
  logic [PW-1:0] cp_k, cp_k_next;
  logic [PW-1:0] cur_len, cur_len_next;

  // latched input transaction
  logic [LEN_W-1:0]   l_len;
  logic [BYTE_W-1:0]  l_byte;
  logic               l_last;
  logic [SLOT_W-1:0]  l_slot;
  logic [INDEX_W-1:0] l_idx;

  logic in_fire;

  // ram ports
  logic            slot_we;
  logic [SW-1:0]   slot_waddr, slot_raddr;
  logic [2*PW-1:0] slot_wdata, slot_rdata;
  logic            tup_we;
  logic [AW-1:0]   tup_waddr, tup_raddr;
  logic [BYTE_W-1:0] tup_wdata, tup_rdata;

  logic [PW-1:0] rd_len, rd_off;

  // result to load into the output register
  logic                res_fire;
  logic [STATUS_W-1:0] res_status;
  logic [SLOT_W-1:0]   res_slot;
  logic [PAGEID_W-1:0] res_page;
  logic [PW-1:0]       res_len;
  logic [BYTE_W-1:0]   res_byte;

  assign in_stall = (state != S_IDLE) || (out_valid && out_stall);
  assign in_fire  = in_valid && !in_stall;
  assign rd_len   = slot_rdata[PW-1:0];
  assign rd_off   = slot_rdata[2*PW-1:PW];

  spm_ram #(.WIDTH(2*PW), .DEPTH(MAX_SLOTS)) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .raddr (slot_raddr),
    .rdata (slot_rdata)
  );

  spm_ram #(.WIDTH(BYTE_W), .DEPTH(PAGE_BYTES)) u_tuple_ram (
    .clk   (clk),
    .we    (tup_we),
    .waddr (tup_waddr),
    .wdata (tup_wdata),
    .raddr (tup_raddr),
    .rdata (tup_rdata)
  );

  always_comb begin
    logic [CALCW-1:0] top;
    logic [CALCW-1:0] fp_c;
    logic [CALCW-1:0] sum;
    logic             room;
    logic             beyond;
    ins_state_t       st;
    logic [PW-1:0]    pos;
    logic [PW-1:0]    ln;

    state_next     = state;
    ins_state_next = ins_state;
    ins_pos_next   = ins_pos;
    ins_len_next   = ins_len;
    fp_next        = fp;
    total_next     = total;
    cp_i_next      = cp_i;
    cp_next_next   = cp_next;
    cp_src_next    = cp_src;
    cp_dst_next    = cp_dst;
    cp_k_next      = cp_k;
    cur_len_next   = cur_len;

    slot_we    = 1'b0;
    slot_waddr = total[SW-1:0];
    slot_wdata = '0;
    slot_raddr = (state == S_CP_SLOT) ? cp_i[SW-1:0] : SW'(slot_select);
    tup_we     = 1'b0;
    tup_waddr  = '0;
    tup_wdata  = l_byte;
    tup_raddr  = AW'(cp_src + cp_k);

    res_fire   = 1'b0;
    res_status = ST_OK;
    res_slot   = '0;
    res_page   = '0;
    res_len    = '0;
    res_byte   = '0;

    fp_c   = CALCW'(fp);
    top    = HEADER_C + (CALCW'(total) * SLOTB_C);
    room   = (total < MAXS_C) && (fp_c >= top) &&
             ((fp_c - top) >= (CALCW'(l_len) + SLOTB_C));
    beyond = XW'(slot_select) >= XW'(total);
    sum    = CALCW'(rd_off) + CALCW'(l_idx);
    st     = ins_state;
    pos    = ins_pos;
    ln     = ins_len;

    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          unique case (mode)
            MODE_INSERT: state_next = S_INS;
            MODE_READ: begin
              if (beyond) begin
                res_fire   = 1'b1;
                res_status = ST_BEYOND;
                res_slot   = slot_select;
              end else begin
                state_next = S_RD_SLOT;
              end
            end
            MODE_DELETE: begin
              if (beyond) begin
                res_fire   = 1'b1;
                res_status = ST_BEYOND;
                res_slot   = slot_select;
              end else begin
                state_next = S_DEL;
              end
            end
            MODE_COMPACT: begin
              ins_state_next = INS_IDLE;
              ins_pos_next   = '0;
              cp_i_next      = '0;
              cp_next_next   = PAGE_P;
              state_next     = S_CP_SLOT;
            end
            MODE_FORMAT: begin
              ins_state_next = INS_IDLE;
              ins_pos_next   = '0;
              total_next     = '0;
              fp_next        = PAGE_P;
              res_fire       = 1'b1;
            end
            default: ;
          endcase
        end
      end
      S_INS: begin
        if (st == INS_IDLE) begin
          if (room) begin
            st  = INS_WRITE;
            ln  = PW'(l_len);
            pos = fp - PW'(l_len);
          end else begin
            st = INS_REJECT;
          end
        end
        if (st == INS_WRITE && pos < fp) begin
          tup_we    = 1'b1;
          tup_waddr = AW'(pos);
          pos       = pos + 1'b1;
        end
        if (l_last) begin
          res_fire = 1'b1;
          if (st == INS_REJECT) begin
            res_status = ST_NOSPACE;
            res_slot   = SLOT_W'(total);
          end else begin
            slot_we    = 1'b1;
            slot_wdata = {fp - ln, ln};
            fp_next    = fp - ln;
            total_next = total + 1'b1;
            res_slot   = SLOT_W'(total);
            res_page   = page_reg;
          end
          st  = INS_IDLE;
          pos = '0;
        end
        ins_state_next = st;
        ins_pos_next   = pos;
        ins_len_next   = ln;
        state_next     = S_IDLE;
      end
      S_RD_SLOT: begin
        state_next = S_IDLE;
        res_slot   = l_slot;
        if (rd_len == '0) begin
          res_fire   = 1'b1;
          res_status = ST_DELETED;
        end else if (PW'(l_idx) >= rd_len || CALCW'(l_idx) >= PAGE_C) begin
          res_fire   = 1'b1;
          res_status = ST_INDEX;
          res_len    = rd_len;
        end else if (sum < PAGE_C) begin
          tup_raddr    = AW'(sum);
          cur_len_next = rd_len;
          state_next   = S_RD_BYTE;
        end else begin
          res_fire = 1'b1;
          res_len  = rd_len;
        end
      end
      S_RD_BYTE: begin
        res_fire   = 1'b1;
        res_slot   = l_slot;
        res_len    = cur_len;
        res_byte   = tup_rdata;
        state_next = S_IDLE;
      end
      S_DEL: begin
        res_fire   = 1'b1;
        res_slot   = l_slot;
        state_next = S_IDLE;
        if (rd_len == '0) begin
          res_status = ST_DELETED;
        end else begin
          slot_we    = 1'b1;
          slot_waddr = SW'(l_slot);
          slot_wdata = {rd_off, {PW{1'b0}}};
        end
      end
      S_CP_SLOT: begin
        if (cp_i >= total) begin
          fp_next    = cp_next;
          res_fire   = 1'b1;
          state_next = S_IDLE;
        end else begin
          state_next = S_CP_CHK;
        end
      end
      S_CP_CHK: begin
        // skip deleted slots and ones that cannot be placed
        if (rd_len == '0 || rd_len > cp_next ||
            CALCW'(rd_off) > (PAGE_C - CALCW'(rd_len))) begin
          cp_i_next  = cp_i + 1'b1;
          state_next = S_CP_SLOT;
        end else begin
          cp_src_next = rd_off;
          cp_dst_next = cp_next - rd_len;
          cp_k_next   = rd_len - 1'b1;
          cur_len_next = rd_len;
          state_next  = S_CP_RD;
        end
      end
      S_CP_RD: begin
        state_next = S_CP_WR;
      end
      S_CP_WR: begin
        // highest byte first so the source is never overwritten early
        tup_we    = 1'b1;
        tup_waddr = AW'(cp_dst + cp_k);
        tup_wdata = tup_rdata;
        if (cp_k == '0) begin
          slot_we      = 1'b1;
          slot_waddr   = cp_i[SW-1:0];
          slot_wdata   = {cp_dst, cur_len};
          cp_next_next = cp_dst;
          cp_i_next    = cp_i + 1'b1;
          state_next   = S_CP_SLOT;
        end else begin
          cp_k_next  = cp_k - 1'b1;
          state_next = S_CP_RD;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ins_state <= INS_IDLE;
      ins_pos   <= '0;
      ins_len   <= '0;
      fp        <= PAGE_P;
      total     <= '0;
      page_reg  <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      ins_state <= ins_state_next;
      ins_pos   <= ins_pos_next;
      ins_len   <= ins_len_next;
      fp        <= fp_next;
      total     <= total_next;
      if (cfg_write_en) begin
        page_reg <= cfg_write_data;
      end
      if (res_fire) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cp_i    <= cp_i_next;
    cp_next <= cp_next_next;
    cp_src  <= cp_src_next;
    cp_dst  <= cp_dst_next;
    cp_k    <= cp_k_next;
    cur_len <= cur_len_next;
    if (in_fire) begin
      l_len  <= tuple_length;
      l_byte <= data_byte;
      l_last <= last_byte;
      l_slot <= slot_select;
      l_idx  <= byte_index;
    end
    if (res_fire) begin
      status           <= res_status;
      slot_number      <= res_slot;
      page_id_out      <= res_page;
      length_out       <= LEN_W'(res_len);
      byte_out         <= res_byte;
      free_pointer_out <= LEN_W'(fp_next);
    end
  end

endmodule

`default_nettype wire
